[rtl/lbc_pkg.sv]
package lbc_pkg;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 32;
    localparam int CNT_W    = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EVICT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    block_id;
        logic [HANDLE_W-1:0] vao_handle;
        logic [HANDLE_W-1:0] vbo_handle;
    } req_t;

    typedef struct packed {
        logic                success;
        logic [KEY_W-1:0]    out_block_id;
        logic [HANDLE_W-1:0] out_vao;
        logic [HANDLE_W-1:0] out_vbo;
        logic [CNT_W-1:0]    occupancy;
    } rsp_t;

    // Directory result for one request; handles come from the handle RAM
    typedef struct packed {
        logic             success;
        logic             report;
        logic [KEY_W-1:0] out_block_id;
        logic [CNT_W-1:0] occupancy;
    } dir_res_t;

endpackage

[rtl/lru_block_cache_unit.sv]
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    lbc_pkg::req_t
// rsp       out        rsp_valid / rsp_ready    lbc_pkg::rsp_t
// cfg       in         cfg_we                   cfg_wdata (capacity)
//
// One request per cycle while responses are taken: the whole directory
// update (key compare, LRU rank shift) runs combinationally between the
// request register and the response register. rsp_valid rises once the
// request moves into the response register; a stalled response delays it.
// Reset empties the cache and sets capacity to 16; no clearing pass.
// A stalled response holds the request register; req_ready falls only
// when both registers are full.
module lru_block_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lbc_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lbc_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [lbc_pkg::CNT_W-1:0] cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HW = lbc_pkg::HANDLE_W;

    lbc_pkg::req_t            req_reg;
    logic                     req_vld_reg;
    lbc_pkg::dir_res_t        res_reg;
    lbc_pkg::dir_res_t        dir_res;
    logic                     rsp_vld_reg;
    logic [lbc_pkg::CNT_W-1:0] cap_reg;
    logic                     fire;
    logic                     ram_we, ram_re;
    logic [IW-1:0]            ram_waddr, ram_raddr;
    logic [2*HW-1:0]          ram_rdata;

    assign fire      = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || fire;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lbc_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Request register valid and response register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (fire)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Capture request and response payloads
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            res_reg <= dir_res;
        end
    end

    lbc_lru_dir #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req       (req_reg),
        .capacity  (cap_reg),
        .res       (dir_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    lbc_ram #(
        .DEPTH (ENTRIES),
        .AW    (IW),
        .DW    (2 * HW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req_reg.vao_handle, req_reg.vbo_handle}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Assemble response; handles only for a reported slot
    always_comb
    begin
        rsp.success      = res_reg.success;
        rsp.out_block_id = res_reg.out_block_id;
        rsp.out_vao      = res_reg.report ? ram_rdata[2*HW-1:HW] : '0;
        rsp.out_vbo      = res_reg.report ? ram_rdata[HW-1:0] : '0;
        rsp.occupancy    = res_reg.occupancy;
    end

    assign rsp_valid = rsp_vld_reg;

endmodule

[rtl/lbc_ram.sv]
module lbc_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lbc_lru_dir.sv]
module lbc_lru_dir #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  lbc_pkg::req_t              req,
    input  logic [lbc_pkg::CNT_W-1:0]  capacity,
    output lbc_pkg::dir_res_t          res,
    output logic                       ram_we,
    output logic [IW-1:0]              ram_waddr,
    output logic                       ram_re,
    output logic [IW-1:0]              ram_raddr
);

    localparam int CW = lbc_pkg::CNT_W;
    localparam int KW = lbc_pkg::KEY_W;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [KW-1:0]      key_reg  [ENTRIES];
    logic [KW-1:0]      key_next [ENTRIES];
    logic [IW-1:0]      rank_reg [ENTRIES];
    logic [IW-1:0]      rank_next[ENTRIES];
    logic [CW-1:0]      count_reg, count_next;

    logic [ENTRIES-1:0] hit_vec, lru_vec, free_vec, free_oh, sel_oh;
    logic [CW-1:0]      cap_eff;
    logic               is_touch, is_put, is_evict, is_extract, is_clear;
    logic               hit, any_lru, evict_on_put;
    logic               do_promote, do_remove, do_insert, dec_en;
    logic [IW-1:0]      sel_rank, ins_rank, hit_idx, free_idx;
    logic [KW-1:0]      sel_key;

    function automatic logic [IW-1:0] enc(input logic [ENTRIES-1:0] oh);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (oh[i])
            begin
                idx = idx | IW'(i);
            end
        end
        return idx;
    endfunction

    // Decode command and clamp capacity to 1..ENTRIES
    always_comb
    begin
        is_touch   = (req.cmd == lbc_pkg::CMD_TOUCH);
        is_put     = (req.cmd == lbc_pkg::CMD_PUT);
        is_evict   = (req.cmd == lbc_pkg::CMD_EVICT);
        is_extract = (req.cmd == lbc_pkg::CMD_EXTRACT);
        is_clear   = (req.cmd == lbc_pkg::CMD_CLEAR);
        if (capacity == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(capacity) > ENTRIES)
        begin
            cap_eff = CW'(ENTRIES);
        end
        else
        begin
            cap_eff = capacity;
        end
    end

    // Compare the key and find the LRU slot in every entry at once
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.block_id);
            lru_vec[i] = valid_reg[i] && (rank_reg[i] == '0);
        end
    end

    // Choose the action
    always_comb
    begin
        hit          = |hit_vec;
        any_lru      = |lru_vec;
        evict_on_put = is_put && !hit && (count_reg >= cap_eff) && any_lru;
        sel_oh       = (is_evict || evict_on_put) ? lru_vec : hit_vec;
        free_vec     = ~valid_reg | (evict_on_put ? lru_vec : '0);
        free_oh      = free_vec & (~free_vec + ENTRIES'(1));
        do_promote   = (is_touch || is_put) && hit;
        do_remove    = (is_extract && hit) || (is_evict && any_lru) || evict_on_put;
        do_insert    = is_put && !hit && (|free_oh);
        dec_en       = do_promote || do_remove;
        hit_idx      = enc(hit_vec);
        free_idx     = enc(free_oh);
        ins_rank     = evict_on_put ? IW'(count_reg - CW'(1)) : IW'(count_reg);
        sel_rank     = '0;
        sel_key      = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel_oh[i])
            begin
                sel_rank = sel_rank | rank_reg[i];
                sel_key  = sel_key | key_reg[i];
            end
        end
    end

    // Next state of the directory
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]  = key_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (is_clear)
        begin
            valid_next = '0;
            count_next = '0;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (dec_en && !sel_oh[i] && valid_reg[i] && (rank_reg[i] > sel_rank))
                begin
                    rank_next[i] = rank_reg[i] - IW'(1);
                end
                if (do_promote && sel_oh[i])
                begin
                    rank_next[i] = IW'(count_reg - CW'(1));
                end
                if (do_remove && sel_oh[i])
                begin
                    valid_next[i] = 1'b0;
                end
                if (do_insert && free_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = req.block_id;
                    rank_next[i]  = ins_rank;
                end
            end
            if (do_insert && !do_remove)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (do_remove && !do_insert)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Hold keys and ranks
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_reg[i]  <= key_next[i];
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Drive result and handle RAM control
    always_comb
    begin
        res.report       = do_remove;
        res.success      = (is_touch && hit) || do_remove || is_clear;
        res.out_block_id = do_remove ? sel_key : '0;
        res.occupancy    = count_next;
        ram_we           = fire && is_put && (hit || do_insert);
        ram_waddr        = hit ? hit_idx : free_idx;
        ram_re           = fire;
        ram_raddr        = enc(sel_oh);
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= ENTRIES)
        else $error("occupancy above entry count");

    a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("occupancy does not match valid slots");

    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("key present in more than one slot");

    a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> $onehot(lru_vec))
        else $error("no single LRU slot");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_clear) |=> (count_reg == '0) && (valid_reg == '0))
        else $error("clear left slots valid");

endmodule

[tb/sv/lru_block_cache_unit_tb.sv]
`timescale 1ns / 100ps

// Tracks cache contents and LRU order, predicts one response per request
class lru_shadow;
    localparam int SLOTS    = 16;
    localparam int KEY_W    = lbc_pkg::KEY_W;
    localparam int HANDLE_W = lbc_pkg::HANDLE_W;
    localparam int CNT_W    = lbc_pkg::CNT_W;

    bit                  slot_used [SLOTS];
    logic [KEY_W-1:0]    slot_key  [SLOTS];
    logic [HANDLE_W-1:0] slot_vao  [SLOTS];
    logic [HANDLE_W-1:0] slot_vbo  [SLOTS];
    int unsigned         slot_age  [SLOTS];
    int unsigned         used_count;
    logic [CNT_W-1:0]    capacity;
    lbc_pkg::rsp_t       pending_rsp[$];
    int unsigned         mismatches;

    function new();
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
        end
        used_count = 0;
        capacity   = lbc_pkg::CAP_RESET;
        mismatches = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function int find_oldest();
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] == 0)
                return i;
        return -1;
    endfunction

    // Report a slot's contents, then drop it and close the age gap
    function void take_slot(int idx, ref lbc_pkg::rsp_t r);
        int unsigned age;
        age            = slot_age[idx];
        r.success      = 1'b1;
        r.out_block_id = slot_key[idx];
        r.out_vao      = slot_vao[idx];
        r.out_vbo      = slot_vbo[idx];
        slot_used[idx] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] > age)
                slot_age[i]--;
        if (used_count > 0)
            used_count--;
    endfunction

    function void make_newest(int idx);
        int unsigned age;
        age = slot_age[idx];
        for (int i = 0; i < SLOTS; i++)
            if (i != idx && slot_used[i] && slot_age[i] > age)
                slot_age[i]--;
        slot_age[idx] = used_count - 1;
    endfunction

    function void note_request(lbc_pkg::req_t q);
        lbc_pkg::rsp_t want;
        int            idx;
        int            free_idx;
        int unsigned   cap;
        cap = capacity;
        if (cap < 1)
            cap = 1;
        if (cap > SLOTS)
            cap = SLOTS;
        want = '0;
        case (q.cmd)
            lbc_pkg::CMD_TOUCH:
            begin
                idx = find_key(q.block_id);
                if (idx >= 0)
                begin
                    make_newest(idx);
                    want.success = 1'b1;
                end
            end
            lbc_pkg::CMD_PUT:
            begin
                idx = find_key(q.block_id);
                if (idx >= 0)
                begin
                    slot_vao[idx] = q.vao_handle;
                    slot_vbo[idx] = q.vbo_handle;
                    make_newest(idx);
                end
                else
                begin
                    // Make room first when at capacity; only one slot goes
                    if (used_count >= cap)
                    begin
                        idx = find_oldest();
                        if (idx >= 0)
                            take_slot(idx, want);
                    end
                    free_idx = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_used[i] && free_idx < 0)
                            free_idx = i;
                    if (free_idx >= 0)
                    begin
                        slot_used[free_idx] = 1'b1;
                        slot_key[free_idx]  = q.block_id;
                        slot_vao[free_idx]  = q.vao_handle;
                        slot_vbo[free_idx]  = q.vbo_handle;
                        slot_age[free_idx]  = used_count;
                        used_count++;
                    end
                end
            end
            lbc_pkg::CMD_EVICT:
            begin
                idx = find_oldest();
                if (idx >= 0)
                    take_slot(idx, want);
            end
            lbc_pkg::CMD_EXTRACT:
            begin
                idx = find_key(q.block_id);
                if (idx >= 0)
                    take_slot(idx, want);
            end
            lbc_pkg::CMD_CLEAR:
            begin
                foreach (slot_used[i])
                    slot_used[i] = 1'b0;
                used_count   = 0;
                want.success = 1'b1;
            end
            default:
                ;
        endcase
        want.occupancy = used_count[CNT_W-1:0];
        pending_rsp.insert(pending_rsp.size(), want);
    endfunction

    function void check_response(lbc_pkg::rsp_t got);
        lbc_pkg::rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response with nothing pending: succ=%0b id=%h occ=%0d",
                         $realtime, got.success, got.out_block_id, got.occupancy);
            return;
        end
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (got.success !== want.success || got.out_block_id !== want.out_block_id ||
            got.out_vao !== want.out_vao || got.out_vbo !== want.out_vbo ||
            got.occupancy !== want.occupancy)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: want succ=%0b id=%h vao=%h vbo=%h occ=%0d", $realtime,
                         want.success, want.out_block_id, want.out_vao, want.out_vbo,
                         want.occupancy);
                $display("%0t: got  succ=%0b id=%h vao=%h vbo=%h occ=%0d", $realtime,
                         got.success, got.out_block_id, got.out_vao, got.out_vbo,
                         got.occupancy);
            end
        end
    endfunction
endclass

module lru_block_cache_unit_tb;

    localparam int          SLOTS       = 16;
    localparam int          PHASE_ITEMS = 130;
    localparam int          LONG_HOLD   = 120;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          CMD_W       = lbc_pkg::CMD_W;
    localparam int          KEY_W       = lbc_pkg::KEY_W;
    localparam int          HANDLE_W    = lbc_pkg::HANDLE_W;
    localparam int          CNT_W       = lbc_pkg::CNT_W;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    lbc_pkg::req_t    req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    lbc_pkg::rsp_t    rsp;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    lru_shadow        mirror = new();
    int unsigned      tx_idle_pct = 10;
    int unsigned      rx_idle_pct = 10;
    bit               long_hold_req = 1'b0;
    int unsigned      cycle_count = 0;
    logic [KEY_W-1:0] key_pool [20];
    logic [CNT_W-1:0] phase_caps [10] = '{5'd31, 5'd16, 5'd1, 5'd4, 5'd17,
                                          5'd0, 5'd9, 5'd2, 5'd12, 5'd16};

    lru_block_cache_unit #(
        .ENTRIES(SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lru_block_cache_unit regression: fail");
        $finish;
    end

    function automatic lbc_pkg::req_t make_req(logic [CMD_W-1:0] c, logic [KEY_W-1:0] key,
                                               logic [HANDLE_W-1:0] vao,
                                               logic [HANDLE_W-1:0] vbo);
        lbc_pkg::req_t q;
        q.cmd        = c;
        q.block_id   = key;
        q.vao_handle = vao;
        q.vbo_handle = vbo;
        return q;
    endfunction

    // Mostly hits and misses on a small key pool, a few stray keys and codes
    function automatic lbc_pkg::req_t random_request(int unsigned pool_size);
        int unsigned      pick;
        logic [CMD_W-1:0] c;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            c = lbc_pkg::CMD_PUT;
        else if (pick < 66)
            c = lbc_pkg::CMD_TOUCH;
        else if (pick < 81)
            c = lbc_pkg::CMD_EXTRACT;
        else if (pick < 96)
            c = lbc_pkg::CMD_EVICT;
        else if (pick < 98)
            c = lbc_pkg::CMD_CLEAR;
        else
            c = lbc_pkg::CMD_CLEAR + CMD_W'($urandom_range(1, 3));
        if ($urandom_range(0, 99) < 5)
            key = KEY_W'($urandom);
        else
            key = key_pool[$urandom_range(0, pool_size - 1)];
        return make_req(c, key, $urandom, $urandom);
    endfunction

    // Offer one request, hold it until taken, then maybe go quiet for a while
    task automatic issue_request(input lbc_pkg::req_t q);
        req_valid <= 1'b1;
        req       <= q;
        do
            @(posedge clk);
        while (!req_ready);
        mirror.note_request(q);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding response
    task automatic wait_all_responses();
        req_valid <= 1'b0;
        while (mirror.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we          <= 1'b0;
        mirror.capacity  = value;
    endtask

    // Response side: check accepted responses, stall in bursts or on request
    initial
    begin : rsp_side
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                mirror.check_response(rsp);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_ready    <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                hold_left  = $urandom_range(0, 11);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int unsigned eff_cap;
        int unsigned pool_size;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty cache, misses, extreme keys and handles, hit update, unknown codes
        issue_request(make_req(lbc_pkg::CMD_EVICT, '0, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_TOUCH, '0, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_EXTRACT, '1, '1, '1));
        issue_request(make_req(lbc_pkg::CMD_PUT, '0, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_PUT, '1, '1, '1));
        issue_request(make_req(lbc_pkg::CMD_PUT, '0, 32'h5555_5555, 32'haaaa_aaaa));
        issue_request(make_req(lbc_pkg::CMD_TOUCH, '1, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_EXTRACT, '0, '0, '0));
        for (int k = 1; k <= 3; k++)
            issue_request(make_req(lbc_pkg::CMD_CLEAR + CMD_W'(k), '1, '1, '1));
        issue_request(make_req(lbc_pkg::CMD_EVICT, '0, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd1, 32'd2, 32'd3));
        issue_request(make_req(lbc_pkg::CMD_CLEAR, '0, '0, '0));

        // Small capacity: put miss at capacity evicts the oldest
        wait_all_responses();
        write_capacity(5'd2);
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd10, 32'h10, 32'h100));
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd11, 32'h11, 32'h110));
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd12, 32'h12, 32'h120));
        issue_request(make_req(lbc_pkg::CMD_TOUCH, 31'd11, '0, '0));
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd13, 32'h13, 32'h130));

        // Zero capacity acts as one; lowered below occupancy, a put evicts once
        wait_all_responses();
        write_capacity(5'd0);
        issue_request(make_req(lbc_pkg::CMD_PUT, 31'd14, 32'h14, 32'h140));
        repeat (3) issue_request(make_req(lbc_pkg::CMD_EVICT, '0, '0, '0));

        wait_all_responses();
        write_capacity(5'd31);
        issue_request(make_req(lbc_pkg::CMD_CLEAR, '0, '0, '0));

        // Random phases, one capacity each, idle-free at the end
        foreach (phase_caps[p])
        begin
            wait_all_responses();
            write_capacity(phase_caps[p]);
            eff_cap = phase_caps[p];
            if (eff_cap < 1)
                eff_cap = 1;
            if (eff_cap > SLOTS)
                eff_cap = SLOTS;
            pool_size = eff_cap + 4;
            foreach (key_pool[i])
                key_pool[i] = KEY_W'($urandom);
            if (p == $size(phase_caps) - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 12 * $urandom_range(0, 2);
                rx_idle_pct = 12 * $urandom_range(0, 2);
            end
            // Back up the pipe: responses stall while requests keep coming
            if (p == 1)
            begin
                tx_idle_pct   = 0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_all_responses();
                issue_request(random_request(pool_size));
            end
        end

        wait_all_responses();
        if (mirror.mismatches == 0 && mirror.pending_rsp.size() == 0)
            $display("lru_block_cache_unit regression: pass");
        else
            $display("lru_block_cache_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/lbc_pkg.sv
rtl/lbc_ram.sv
rtl/lbc_lru_dir.sv
rtl/lru_block_cache_unit.sv
tb/sv/lru_block_cache_unit_tb.sv
